// ===== design/message_tag_match_queues_defines.svh =====
// ----------------------------------------------------------------------------
// message_tag_match_queues_defines
// Assertion macros shared by the tag matching block.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_TAG_MATCH_QUEUES_DEFINES_SVH
`define MESSAGE_TAG_MATCH_QUEUES_DEFINES_SVH

// Asserts that a condition implies a consequence on the same edge.
`define MTMQ_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Asserts that a condition implies a consequence on the next edge.
`define MTMQ_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mtmq_pkg.sv =====
// ----------------------------------------------------------------------------
// mtmq_pkg
// Types and constants shared by the tag matching queues.
// ----------------------------------------------------------------------------
`default_nettype none
package mtmq_pkg;
  localparam int unsigned QueueDepthDefault = 64;
  localparam int unsigned KeyW    = 63;
  localparam int unsigned TagW    = 31;
  localparam int unsigned RankW   = 16;
  localparam int unsigned CtxW    = 16;
  localparam int unsigned HandleW = 16;
  localparam int unsigned SenderW = 32;
  localparam int unsigned OpW     = 3;
  localparam int unsigned CountW  = 7;

  typedef enum logic [OpW-1:0] {
    OP_POST    = 3'd0,
    OP_ARRIVE  = 3'd1,
    OP_PROBE   = 3'd2,
    OP_CANCEL  = 3'd3,
    OP_REMOVE  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_APPEND,
    ST_DONE
  } state_t;

  // Key mask for a pair of wildcard flags: bit 0 any source, bit 1 any tag.
  function automatic logic [KeyW-1:0] wild_mask(input logic [1:0] wild);
    logic [KeyW-1:0] m;
    m = '1;
    if (wild[0]) m[TagW +: RankW] = '0;
    if (wild[1]) m[TagW-1:0] = '0;
    return m;
  endfunction
endpackage
`default_nettype wire

// ===== design/mtmq_if.sv =====
// ----------------------------------------------------------------------------
// mtmq_in_if / mtmq_out_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
`default_nettype none
interface mtmq_in_if;
  logic                            valid;
  logic                            ready;
  logic [mtmq_pkg::OpW-1:0]        op;
  logic [mtmq_pkg::CtxW-1:0]       context_req;
  logic [mtmq_pkg::RankW-1:0]      src_rank;
  logic                            wild_src;
  logic [mtmq_pkg::TagW-1:0]       msg_tag;
  logic                            any_tag;
  logic [mtmq_pkg::SenderW-1:0]    sender_id;
  logic [mtmq_pkg::HandleW-1:0]    req_handle;
  modport source (output valid, op, context_req, src_rank, wild_src, msg_tag,
                  any_tag, sender_id, req_handle, input ready);
  modport sink (input valid, op, context_req, src_rank, wild_src, msg_tag,
                any_tag, sender_id, req_handle, output ready);
endinterface

interface mtmq_out_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [mtmq_pkg::HandleW-1:0]    handle;
  logic [mtmq_pkg::RankW-1:0]      match_source;
  logic [mtmq_pkg::TagW-1:0]       match_tag;
  logic                            status;
  logic [mtmq_pkg::CountW-1:0]     posted_count;
  logic [mtmq_pkg::CountW-1:0]     unexpected_count;
  modport source (output valid, found, handle, match_source, match_tag, status,
                  posted_count, unexpected_count, input ready);
  modport sink (input valid, found, handle, match_source, match_tag, status,
                posted_count, unexpected_count, output ready);
endinterface
`default_nettype wire

// ===== design/mtmq_queue.sv =====
// ----------------------------------------------------------------------------
// mtmq_queue
// One age-ordered entry store with a single read port and a single write
// port; the sequencer walks it for searches and compaction.
// ----------------------------------------------------------------------------
`default_nettype none
module mtmq_queue #(
  parameter int unsigned DEPTH = mtmq_pkg::QueueDepthDefault,
  parameter int unsigned DW    = 8
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire logic [DW-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr,
  output logic      [DW-1:0]             rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/message_tag_match_queues.sv =====
// ----------------------------------------------------------------------------
// message_tag_match_queues
// Receive-side tag matching over a posted-receive queue and an unexpected
// message queue, each QUEUE_DEPTH entries held in a memory with one read and
// one write port. A request is taken, then one comparator walks the chosen
// queue one entry a cycle (read data registered); a removed entry is closed
// up by moving every later entry down one place at one entry a cycle, and a
// miss that a post or arrival turns into an append writes the new entry at
// the tail. The result word is then offered until taken, and the block
// returns to idle. A request stops at its first match or appends, while a
// cancel walks the whole queue before closing up behind the newest matching
// entry. The block takes no new request until the result word has been taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "message_tag_match_queues_defines.svh"
module message_tag_match_queues #(
  parameter int unsigned QUEUE_DEPTH = mtmq_pkg::QueueDepthDefault
) (
  input wire logic  clk,
  input wire logic  rst_n,
  mtmq_in_if.sink   in_ch,
  mtmq_out_if.source out_ch
);
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned KW = mtmq_pkg::KeyW;
  localparam int unsigned HW = mtmq_pkg::HandleW;
  localparam int unsigned PW = KW + 2 + HW;
  localparam int unsigned UW = KW + HW + mtmq_pkg::SenderW;
  localparam int unsigned CW = mtmq_pkg::CountW;

  mtmq_pkg::state_t state_r, state_nxt;

  logic [FW-1:0] pfill_r, ufill_r;
  logic [FW-1:0] idx_r;        // next address to read
  logic          rd_vld_r;     // read data valid for address idx_r-1
  logic          is_post_r;    // true when the posted queue is walked
  logic [mtmq_pkg::OpW-1:0]     op_r;
  logic [KW-1:0]                key_r;
  logic [1:0]                   wild_r;
  logic [mtmq_pkg::SenderW-1:0] sender_r;
  logic [HW-1:0]                rh_r;
  logic          hit_r;
  logic [FW-1:0] hit_at_r;
  logic [FW-1:0] wptr_r;       // compaction destination
  logic          found_r, status_r;
  logic [HW-1:0] handle_r;
  logic [KW-1:0] mkey_r;

  logic          p_we, u_we;
  logic [AW-1:0] p_wa, u_wa, p_ra, u_ra;
  logic [PW-1:0] p_wd, p_rd;
  logic [UW-1:0] u_wd, u_rd;

  mtmq_queue #(.DEPTH(QUEUE_DEPTH), .DW(PW)) u_posted (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  mtmq_queue #(.DEPTH(QUEUE_DEPTH), .DW(UW)) u_unexp (
    .clk(clk), .we(u_we), .waddr(u_wa), .wdata(u_wd), .raddr(u_ra), .rdata(u_rd));

  // Fields of the entry that was read last cycle.
  logic [KW-1:0] e_key;
  logic [1:0]    e_wild;
  logic [HW-1:0] e_handle;
  logic [mtmq_pkg::SenderW-1:0] e_sender;
  logic [KW-1:0] mask;
  logic          e_hit;
  logic [FW-1:0] fill;
  logic [FW-1:0] e_at;
  logic          accept, scan_end, stop_first;

  always_comb begin
    e_key    = is_post_r ? p_rd[PW-1 -: KW] : u_rd[UW-1 -: KW];
    e_wild   = p_rd[HW +: 2];
    e_handle = is_post_r ? p_rd[HW-1:0] : u_rd[mtmq_pkg::SenderW +: HW];
    e_sender = u_rd[mtmq_pkg::SenderW-1:0];
    e_at     = idx_r - FW'(1);
    mask     = '1;
    e_hit    = 1'b0;
    case (op_r)
      mtmq_pkg::OP_POST, mtmq_pkg::OP_PROBE: begin
        mask  = mtmq_pkg::wild_mask(wild_r);
        e_hit = (e_key & mask) == (key_r & mask);
      end
      mtmq_pkg::OP_ARRIVE: begin
        mask  = mtmq_pkg::wild_mask(e_wild);
        e_hit = (e_key & mask) == (key_r & mask);
      end
      mtmq_pkg::OP_CANCEL: e_hit = (e_key == key_r) && (e_sender == sender_r);
      mtmq_pkg::OP_REMOVE: e_hit = e_handle == rh_r;
      default: e_hit = 1'b0;
    endcase
    fill       = is_post_r ? pfill_r : ufill_r;
    // Cancel keeps looking for the newest match; the rest stop at the oldest.
    stop_first = rd_vld_r && e_hit && (op_r != mtmq_pkg::OP_CANCEL);
    scan_end   = stop_first || (idx_r >= fill && !rd_vld_r) ||
                 (rd_vld_r && idx_r >= fill);
  end

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == mtmq_pkg::ST_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtmq_pkg::ST_IDLE: if (accept) state_nxt = mtmq_pkg::ST_SCAN;
      mtmq_pkg::ST_SCAN: begin
        if (scan_end) begin
          if (stop_first || (hit_r || (rd_vld_r && e_hit))) begin
            if (op_r == mtmq_pkg::OP_PROBE) state_nxt = mtmq_pkg::ST_DONE;
            else state_nxt = mtmq_pkg::ST_SHIFT;
          end else if (op_r == mtmq_pkg::OP_POST || op_r == mtmq_pkg::OP_ARRIVE) begin
            state_nxt = mtmq_pkg::ST_APPEND;
          end else begin
            state_nxt = mtmq_pkg::ST_DONE;
          end
        end
      end
      mtmq_pkg::ST_SHIFT:
        if (rd_vld_r && wptr_r + FW'(2) >= fill) state_nxt = mtmq_pkg::ST_DONE;
        else if (!rd_vld_r && wptr_r + FW'(1) >= fill) state_nxt = mtmq_pkg::ST_DONE;
      mtmq_pkg::ST_APPEND: state_nxt = mtmq_pkg::ST_DONE;
      mtmq_pkg::ST_DONE: if (out_ch.ready) state_nxt = mtmq_pkg::ST_IDLE;
      default: state_nxt = mtmq_pkg::ST_IDLE;
    endcase
  end

  // Memory port control.
  logic [AW-1:0] ra;
  always_comb begin
    ra   = idx_r[AW-1:0];
    p_ra = ra;
    u_ra = ra;
    p_we = 1'b0;
    u_we = 1'b0;
    p_wa = wptr_r[AW-1:0];
    u_wa = wptr_r[AW-1:0];
    p_wd = p_rd;
    u_wd = u_rd;
    case (state_r)
      mtmq_pkg::ST_SHIFT: begin
        p_we = is_post_r && rd_vld_r;
        u_we = !is_post_r && rd_vld_r;
      end
      mtmq_pkg::ST_APPEND: begin
        p_wa = pfill_r[AW-1:0];
        u_wa = ufill_r[AW-1:0];
        p_wd = {key_r, wild_r, rh_r};
        u_wd = {key_r, rh_r, sender_r};
        p_we = is_post_r && (pfill_r < FW'(QUEUE_DEPTH));
        u_we = !is_post_r && (ufill_r < FW'(QUEUE_DEPTH));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtmq_pkg::ST_IDLE;
      pfill_r <= '0;
      ufill_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        mtmq_pkg::ST_IDLE: begin
          rd_vld_r <= 1'b0;
          if (accept) begin
            op_r      <= in_ch.op;
            key_r     <= {in_ch.context_req, in_ch.src_rank, in_ch.msg_tag};
            wild_r    <= {in_ch.any_tag, in_ch.wild_src};
            sender_r  <= in_ch.sender_id;
            rh_r      <= in_ch.req_handle;
            is_post_r <= (in_ch.op == mtmq_pkg::OP_ARRIVE) ||
                         (in_ch.op == mtmq_pkg::OP_REMOVE);
            idx_r     <= '0;
            hit_r     <= 1'b0;
            found_r   <= 1'b0;
            status_r  <= 1'b0;
            handle_r  <= '0;
            mkey_r    <= '0;
          end
        end
        mtmq_pkg::ST_SCAN: begin
          if (rd_vld_r && e_hit) begin
            hit_r    <= 1'b1;
            hit_at_r <= e_at;
            found_r  <= 1'b1;
            handle_r <= e_handle;
            mkey_r   <= e_key;
          end
          if (scan_end) begin
            // Restart reads just after the hit for compaction.
            if (rd_vld_r && e_hit) begin
              wptr_r <= e_at;
              idx_r  <= e_at + FW'(1);
            end else begin
              wptr_r <= hit_at_r;
              idx_r  <= hit_at_r + FW'(1);
            end
            rd_vld_r <= 1'b0;
            if (state_nxt == mtmq_pkg::ST_APPEND) is_post_r <= !is_post_r;
          end else begin
            idx_r    <= idx_r + FW'(1);
            rd_vld_r <= idx_r < fill;
          end
        end
        mtmq_pkg::ST_SHIFT: begin
          if (rd_vld_r) wptr_r <= wptr_r + FW'(1);
          idx_r    <= idx_r + FW'(1);
          rd_vld_r <= idx_r < fill;
          if (state_nxt == mtmq_pkg::ST_DONE) begin
            if (is_post_r) pfill_r <= pfill_r - FW'(1);
            else ufill_r <= ufill_r - FW'(1);
          end
        end
        mtmq_pkg::ST_APPEND: begin
          if (is_post_r) begin
            if (pfill_r < FW'(QUEUE_DEPTH)) begin
              pfill_r <= pfill_r + FW'(1);
              handle_r <= rh_r;
            end else status_r <= 1'b1;
          end else begin
            if (ufill_r < FW'(QUEUE_DEPTH)) begin
              ufill_r <= ufill_r + FW'(1);
              handle_r <= rh_r;
            end else status_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Post appends to posted even though it walks unexpected; fix the target.
  // The append state writes the posted queue for a post, unexpected for an
  // arrival, so the queue selection flips on entry to it.
  logic append_to_posted;
  assign append_to_posted = (op_r == mtmq_pkg::OP_POST);

  // Outputs.
  always_comb begin
    out_ch.valid            = (state_r == mtmq_pkg::ST_DONE);
    out_ch.found            = found_r;
    out_ch.handle           = handle_r;
    out_ch.match_source     = mkey_r[mtmq_pkg::TagW +: mtmq_pkg::RankW];
    out_ch.match_tag        = mkey_r[mtmq_pkg::TagW-1:0];
    out_ch.status           = status_r;
    out_ch.posted_count     = CW'(pfill_r);
    out_ch.unexpected_count = CW'(ufill_r);
  end

  `MTMQ_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1,
    (pfill_r <= FW'(QUEUE_DEPTH)) && (ufill_r <= FW'(QUEUE_DEPTH)), "fill overflow")
  `MTMQ_ASSERT_IMP(a_found_no_status, clk, rst_n, out_ch.valid,
    !(out_ch.found && out_ch.status), "found and full together")
  `MTMQ_ASSERT_NEXT(a_hold_result, clk, rst_n, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.handle), "result dropped")
  `MTMQ_ASSERT_IMP(a_append_target, clk, rst_n,
    state_r == mtmq_pkg::ST_APPEND, is_post_r == append_to_posted, "wrong append queue")
endmodule
`default_nettype wire
